### sv/aetp_pkg.sv
`timescale 1ns / 1ps

package aetp_pkg;

    localparam int MAX_NAME_BYTES = 1024;
    localparam int NAME_W         = 10;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_DONE     = 4'd1;
    localparam logic [3:0] ST_BADSIG   = 4'd2;
    localparam logic [3:0] ST_UPPER    = 4'd3;
    localparam logic [3:0] ST_HDR      = 4'd4;
    localparam logic [3:0] ST_PAST     = 4'd5;
    localparam logic [3:0] ST_NAME     = 4'd6;
    localparam logic [3:0] ST_ENTRY    = 4'd7;
    localparam logic [3:0] ST_MISMATCH = 4'd8;

    localparam logic [1:0] FMT_UNKNOWN = 2'd0;
    localparam logic [1:0] FMT_COMP    = 2'd1;
    localparam logic [1:0] FMT_STORED  = 2'd2;
    localparam logic [1:0] FMT_UPPER   = 2'd3;

    localparam logic [31:0] SIG_COMP   = "FArC";
    localparam logic [31:0] SIG_STORED = "FArc";
    localparam logic [31:0] SIG_UPPER  = "FARC";

    localparam logic [32:0] HDR_BIAS = 33'd8;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [3:0]        status;
        logic [31:0]       entry_index;
        logic [31:0]       entry_offset;
        logic [31:0]       stored_size;
        logic [31:0]       unpacked_size;
        logic              is_compressed;
        logic [NAME_W-1:0] name_length;
        logic [1:0]        format;
        logic [31:0]       alignment;
        logic [32:0]       header_end;
        logic              any_compressed;
        logic              last;
    } t_out;

    function automatic t_out mk_res(
        input logic [3:0]        status,
        input logic [31:0]       idx,
        input logic [31:0]       off,
        input logic [31:0]       st,
        input logic [31:0]       unp,
        input logic              comp,
        input logic [NAME_W-1:0] nlen,
        input logic [1:0]        fmt,
        input logic [31:0]       align,
        input logic [32:0]       hend,
        input logic              seen,
        input logic              last
    );
        t_out r;
        r.status         = status;
        r.entry_index    = idx;
        r.entry_offset   = off;
        r.stored_size    = st;
        r.unpacked_size  = unp;
        r.is_compressed  = comp;
        r.name_length    = nlen;
        r.format         = fmt;
        r.alignment      = align;
        r.header_end     = hend;
        r.any_compressed = seen;
        r.last           = last;
        return r;
    endfunction

endpackage

### sv/aetp_parse.sv
`timescale 1ns / 1ps

module aetp_parse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_go,
    input  aetp_pkg::t_in i_item,
    output aetp_pkg::t_out o_res0,
    output aetp_pkg::t_out o_res1,
    output logic [1:0]    o_nres
);
    import aetp_pkg::*;

    typedef enum logic [2:0] {
        PH_SIG, PH_HSIZE, PH_ALIGN, PH_NAME, PH_OFF, PH_SIZE, PH_UNP, PH_HALT
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [31:0]       r_fl;
    logic [31:0]       r_pos, n_pos;
    logic [31:0]       r_shift, n_shift;
    logic [1:0]        r_wbc, n_wbc;
    logic [1:0]        r_form, n_form;
    logic [32:0]       r_hend, n_hend;
    logic [31:0]       r_align, n_align;
    logic [NAME_W-1:0] r_nc, n_nc;
    logic [31:0]       r_off, n_off;
    logic [31:0]       r_stored, n_stored;
    logic [31:0]       r_ecnt, n_ecnt;
    logic              r_seen, n_seen;

    logic        v_fail, v_entry, v_check, v_comp, v_bad;
    logic [3:0]  v_fst;
    logic [31:0] v_unp;
    logic [32:0] v_end;
    t_out        v_chk;
    logic        v_has_chk;

    always_comb begin
        n_phase = r_phase;  n_pos = r_pos;     n_shift = r_shift; n_wbc = r_wbc;
        n_form = r_form;    n_hend = r_hend;   n_align = r_align; n_nc = r_nc;
        n_off = r_off;      n_stored = r_stored; n_ecnt = r_ecnt; n_seen = r_seen;
        v_fail = 1'b0; v_fst = ST_OK; v_entry = 1'b0; v_check = 1'b0;
        v_comp = 1'b0; v_unp = '0; v_bad = 1'b0; v_end = '0;
        v_has_chk = 1'b0;
        v_chk = '0;
        o_res0 = '0;
        o_res1 = '0;
        o_nres = 2'd0;

        if (i_go) begin
            if (i_item.op) begin
                // restart: clear parse state, keep file length
                n_phase = PH_SIG; n_pos = '0; n_shift = '0; n_wbc = '0;
                n_form = FMT_UNKNOWN; n_hend = '0; n_align = '0; n_nc = '0;
                n_off = '0; n_stored = '0; n_ecnt = '0; n_seen = 1'b0;
            end else if (r_phase != PH_HALT) begin
                if (r_pos >= r_fl) begin
                    v_fail = 1'b1;
                    v_fst  = ST_PAST;
                end else begin
                    n_pos = r_pos + 32'd1;
                    if (r_phase == PH_NAME) begin
                        if (i_item.data_byte == 8'd0) begin
                            n_phase = PH_OFF;
                            n_wbc   = '0;
                            n_shift = '0;
                        end else if (r_nc == NAME_W'(MAX_NAME_BYTES - 1)) begin
                            v_fail = 1'b1;
                            v_fst  = ST_NAME;
                        end else begin
                            n_nc = r_nc + NAME_W'(1);
                        end
                    end else begin
                        n_shift = {r_shift[23:0], i_item.data_byte};
                        n_wbc   = r_wbc + 2'd1;
                        if (r_wbc == 2'd3) begin
                            case (r_phase)
                                PH_SIG: begin
                                    if (n_shift == SIG_COMP) begin
                                        n_form  = FMT_COMP;
                                        n_phase = PH_HSIZE;
                                    end else if (n_shift == SIG_STORED) begin
                                        n_form  = FMT_STORED;
                                        n_phase = PH_HSIZE;
                                    end else if (n_shift == SIG_UPPER) begin
                                        n_form = FMT_UPPER;
                                        v_fail = 1'b1;
                                        v_fst  = ST_UPPER;
                                    end else begin
                                        v_fail = 1'b1;
                                        v_fst  = ST_BADSIG;
                                    end
                                end
                                PH_HSIZE: begin
                                    n_hend  = {1'b0, n_shift} + HDR_BIAS;
                                    n_phase = PH_ALIGN;
                                end
                                PH_ALIGN: begin
                                    n_align = n_shift;
                                    if (r_hend > {1'b0, r_fl}) begin
                                        v_fail = 1'b1;
                                        v_fst  = ST_HDR;
                                    end else begin
                                        v_check = 1'b1;
                                    end
                                end
                                PH_OFF: begin
                                    n_off   = n_shift;
                                    n_phase = PH_SIZE;
                                end
                                PH_SIZE: begin
                                    n_stored = n_shift;
                                    if (r_form == FMT_COMP) begin
                                        n_phase = PH_UNP;
                                    end else begin
                                        v_entry = 1'b1;
                                        v_unp   = n_shift;
                                    end
                                end
                                PH_UNP: begin
                                    v_entry = 1'b1;
                                    v_comp  = (n_shift != 32'd0) && (n_shift != r_stored);
                                    v_unp   = (n_shift == 32'd0) ? r_stored : n_shift;
                                end
                                default: begin
                                    n_phase = PH_HALT;
                                end
                            endcase
                        end
                    end
                end
            end

            // bounds check on a completed entry
            if (v_entry) begin
                v_end = {1'b0, n_off} + {1'b0, n_stored};
                v_bad = (r_nc == '0) || (n_off > r_fl) || (v_end > {1'b0, r_fl}) ||
                        ((n_stored != 32'd0) && ({1'b0, n_off} < r_hend));
                if (v_bad) begin
                    v_fail = 1'b1;
                    v_fst  = ST_ENTRY;
                end else begin
                    n_seen  = r_seen | v_comp;
                    n_ecnt  = r_ecnt + 32'd1;
                    v_check = 1'b1;
                end
            end

            if (v_fail) begin
                n_phase = PH_HALT;
                o_res0  = mk_res(v_fst, r_ecnt, '0, '0, '0, 1'b0, '0, n_form, n_align,
                                 n_hend, r_seen, 1'b1);
                o_nres  = 2'd1;
            end else begin
                // loop test: another entry, done, or table end mismatch
                if (v_check) begin
                    if ({1'b0, n_pos} < n_hend) begin
                        n_phase = PH_NAME;
                        n_nc    = '0;
                    end else begin
                        v_has_chk = 1'b1;
                        n_phase   = PH_HALT;
                        v_chk = mk_res(({1'b0, n_pos} == n_hend) ? ST_DONE : ST_MISMATCH,
                                       n_ecnt, '0, '0, '0, 1'b0, '0, n_form, n_align,
                                       n_hend, n_seen, 1'b1);
                    end
                end
                if (v_entry) begin
                    o_res0 = mk_res(ST_OK, r_ecnt, n_off, n_stored, v_unp, v_comp, r_nc,
                                    n_form, n_align, n_hend, n_seen, !v_has_chk);
                    o_res1 = v_chk;
                    o_nres = v_has_chk ? 2'd2 : 2'd1;
                end else if (v_has_chk) begin
                    o_res0 = v_chk;
                    o_nres = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIG;  r_fl <= '0;     r_pos <= '0;    r_shift <= '0;
            r_wbc <= '0;        r_form <= FMT_UNKNOWN;          r_hend <= '0;
            r_align <= '0;      r_nc <= '0;     r_off <= '0;    r_stored <= '0;
            r_ecnt <= '0;       r_seen <= 1'b0;
        end else begin
            r_phase <= n_phase; r_pos <= n_pos; r_shift <= n_shift; r_wbc <= n_wbc;
            r_form <= n_form;   r_hend <= n_hend; r_align <= n_align; r_nc <= n_nc;
            r_off <= n_off;     r_stored <= n_stored; r_ecnt <= n_ecnt; r_seen <= n_seen;
            if (i_cfg_we) begin
                r_fl <= i_cfg_data;
            end
        end
    end

endmodule

### sv/aetp_outq.sv
`timescale 1ns / 1ps

module aetp_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  aetp_pkg::t_out i_res0,
    input  aetp_pkg::t_out i_res1,
    input  logic [1:0]     i_nres,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_stall,
    output aetp_pkg::t_out o_data
);
    import aetp_pkg::*;

    t_out       r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       v_pop;

    // room for a full pair of words, regardless of this cycle's pop
    assign o_room  = (r_cnt <= 3'd2);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rp];
    assign v_pop   = o_valid && !i_stall;

    always_comb begin
        n_wp  = r_wp + i_nres;
        n_rp  = r_rp + {1'b0, v_pop};
        n_cnt = r_cnt + {1'b0, i_nres} - {2'b0, v_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_nres != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_nres == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

### sv/archive_entry_table_parser_core.sv
`timescale 1ns / 1ps
// Archive entry-table parser.
// Input channel (i_valid / o_stall, payload i_data): one archive byte per
// word in file order, or a restart word (op = 1) that rewinds the parse to
// position zero. Output channel (o_valid / i_stall, payload o_data): one word
// per parsed entry, plus a final done or error word; last marks the final
// word caused by one input byte.
// File length is written through i_cfg_we / i_cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce. It is kept across restarts.
// Path: a byte is held in the input register, then one pass of parse logic
// writes its result words into the output queue, which presents them; the
// byte waits in the input register while the queue has no room.
// Throughput: one byte per cycle. A byte that completes an entry and also
// ends the table yields two words, which drain at one word per cycle while the
// receiver does not stall, through a four-word output queue; the input stalls
// only while that queue cannot take two more words.
// Reset clears the parse state and sets the file length to zero.
// When the receiver stalls, the current output word holds and the queue
// fills; the input then stalls until room returns. No word is dropped.

module archive_entry_table_parser_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  aetp_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output aetp_pkg::t_out o_data,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_data
);
    import aetp_pkg::*;

    logic       r_in_valid, n_in_valid;
    t_in        r_in;
    logic       v_room, v_go, v_accept;
    t_out       v_res0, v_res1;
    logic [1:0] v_nres;

    assign v_go     = r_in_valid && v_room;
    assign o_stall  = r_in_valid && !v_room;
    assign v_accept = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (v_accept) begin
            n_in_valid = 1'b1;
        end else if (v_go) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_accept) begin
            r_in <= i_data;
        end
    end

    aetp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_go       (v_go),
        .i_item     (r_in),
        .o_res0     (v_res0),
        .o_res1     (v_res1),
        .o_nres     (v_nres)
    );

    aetp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res0  (v_res0),
        .i_res1  (v_res1),
        .i_nres  (v_nres),
        .o_room  (v_room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import aetp_pkg::*;

    localparam int LONG_HOLD    = 200;
    localparam int SETTLE_TICKS = 8;
    localparam int DRAIN_TICKS  = 12;

    typedef enum logic [2:0] {
        P_SIG, P_HSIZE, P_ALIGN, P_NAME, P_OFF, P_SIZE, P_UNP, P_HALT
    } t_parse_phase;

    typedef enum int {
        A_GOOD, A_BADSIG, A_UPPER, A_SIZE_SKEW, A_BADENTRY, A_CUT, A_NOISE
    } t_arc_kind;

    // Tracks the parse of the byte stream and holds the words still owed.
    class t_parse_scoreboard;
        logic [31:0]  file_len;
        t_parse_phase ph;
        logic [31:0]  pos;
        logic [31:0]  shreg;
        logic [1:0]   nbytes;
        logic [1:0]   fmt;
        logic [32:0]  hdr_end;
        logic [31:0]  align_w;
        logic [9:0]   name_cnt;
        logic [31:0]  cur_off;
        logic [31:0]  cur_st;
        logic [31:0]  n_entries;
        logic         any_comp;
        t_out         due_words[$];
        int unsigned  errors;
        int unsigned  live_bytes;

        function new();
            file_len   = '0;
            errors     = 0;
            live_bytes = 0;
            rewind();
        endfunction

        function void rewind();
            ph        = P_SIG;
            pos       = '0;
            shreg     = '0;
            nbytes    = '0;
            fmt       = FMT_UNKNOWN;
            hdr_end   = '0;
            align_w   = '0;
            name_cnt  = '0;
            cur_off   = '0;
            cur_st    = '0;
            n_entries = '0;
            any_comp  = 1'b0;
        endfunction

        function void set_file_length(logic [31:0] v);
            file_len = v;
        endfunction

        function int unsigned pending();
            return due_words.size();
        endfunction

        function void emit(logic [3:0] status, logic [31:0] idx, logic [31:0] off,
                           logic [31:0] st, logic [31:0] unp, logic comp,
                           logic [9:0] nlen, logic last_w);
            t_out w;
            w.status         = status;
            w.entry_index    = idx;
            w.entry_offset   = off;
            w.stored_size    = st;
            w.unpacked_size  = unp;
            w.is_compressed  = comp;
            w.name_length    = nlen;
            w.format         = fmt;
            w.alignment      = align_w;
            w.header_end     = hdr_end;
            w.any_compressed = any_comp;
            w.last           = last_w;
            due_words = {due_words, w};
        endfunction

        function void stop_with(logic [3:0] status);
            emit(status, n_entries, '0, '0, '0, 1'b0, '0, 1'b1);
            ph = P_HALT;
        endfunction

        // Decide between another entry, done, or an overrun of the table.
        function void table_end_check();
            if ({1'b0, pos} < hdr_end) begin
                ph       = P_NAME;
                name_cnt = '0;
            end else if ({1'b0, pos} == hdr_end) begin
                emit(ST_DONE, n_entries, '0, '0, '0, 1'b0, '0, 1'b1);
                ph = P_HALT;
            end else begin
                stop_with(ST_MISMATCH);
            end
        endfunction

        function void close_entry(logic [31:0] unp, logic comp);
            logic bad;
            t_out w;
            bad = (name_cnt == '0) ||
                  ({1'b0, cur_off} > {1'b0, file_len}) ||
                  ({1'b0, cur_off} + {1'b0, cur_st} > {1'b0, file_len}) ||
                  (cur_st != '0 && {1'b0, cur_off} < hdr_end);
            if (bad) begin
                stop_with(ST_ENTRY);
                return;
            end
            if (comp)
                any_comp = 1'b1;
            emit(ST_OK, n_entries, cur_off, cur_st, unp, comp, name_cnt, 1'b0);
            n_entries++;
            table_end_check();
            // the final word of this byte carries last
            w = due_words.pop_back();
            w.last = 1'b1;
            due_words = {due_words, w};
        endfunction

        function void take_word(t_in w);
            logic [31:0] unp;
            logic        comp;
            logic        word_full;
            live_bytes++;
            if (w.op) begin
                rewind();
                return;
            end
            if (ph == P_HALT)
                return;
            if (pos >= file_len) begin
                stop_with(ST_PAST);
                return;
            end
            pos++;
            if (ph == P_NAME) begin
                if (w.data_byte == 8'h00) begin
                    ph     = P_OFF;
                    nbytes = '0;
                    shreg  = '0;
                end else if (int'(name_cnt) >= MAX_NAME_BYTES - 1) begin
                    stop_with(ST_NAME);
                end else begin
                    name_cnt++;
                end
                return;
            end
            shreg     = {shreg[23:0], w.data_byte};
            word_full = (nbytes == 2'd3);
            nbytes++;
            if (!word_full)
                return;
            case (ph)
                P_SIG: begin
                    if (shreg == SIG_COMP) begin
                        fmt = FMT_COMP;
                        ph  = P_HSIZE;
                    end else if (shreg == SIG_STORED) begin
                        fmt = FMT_STORED;
                        ph  = P_HSIZE;
                    end else if (shreg == SIG_UPPER) begin
                        fmt = FMT_UPPER;
                        stop_with(ST_UPPER);
                    end else begin
                        stop_with(ST_BADSIG);
                    end
                end
                P_HSIZE: begin
                    hdr_end = {1'b0, shreg} + HDR_BIAS;
                    ph      = P_ALIGN;
                end
                P_ALIGN: begin
                    align_w = shreg;
                    if (hdr_end > {1'b0, file_len})
                        stop_with(ST_HDR);
                    else
                        table_end_check();
                end
                P_OFF: begin
                    cur_off = shreg;
                    ph      = P_SIZE;
                end
                P_SIZE: begin
                    cur_st = shreg;
                    if (fmt == FMT_COMP)
                        ph = P_UNP;
                    else
                        close_entry(cur_st, 1'b0);
                end
                P_UNP: begin
                    unp  = shreg;
                    comp = (unp != '0) && (unp != cur_st);
                    // zero unpacked size falls back to the stored size
                    if (!comp && unp == '0)
                        unp = cur_st;
                    close_entry(unp, comp);
                end
                default: ph = P_HALT;
            endcase
        endfunction

        function void cmp(string field, logic [32:0] want, logic [32:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_out got);
            t_out want;
            if (due_words.size() == 0) begin
                $error("result word with none expected: status %0d index %0d",
                       got.status, got.entry_index);
                errors++;
                return;
            end
            want = due_words.pop_front();
            cmp("status", want.status, got.status);
            cmp("entry_index", want.entry_index, got.entry_index);
            cmp("entry_offset", want.entry_offset, got.entry_offset);
            cmp("stored_size", want.stored_size, got.stored_size);
            cmp("unpacked_size", want.unpacked_size, got.unpacked_size);
            cmp("is_compressed", want.is_compressed, got.is_compressed);
            cmp("name_length", want.name_length, got.name_length);
            cmp("format", want.format, got.format);
            cmp("alignment", want.alignment, got.alignment);
            cmp("header_end", want.header_end, got.header_end);
            cmp("any_compressed", want.any_compressed, got.any_compressed);
            cmp("last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    t_in         i_data     = '0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    t_out        o_data;
    logic        i_cfg_we   = 1'b0;
    logic [31:0] i_cfg_data = '0;

    t_parse_scoreboard trk = new();
    t_in         stim_words[$];
    logic [31:0] cur_len   = '0;
    bit          idle_on   = 1'b1;
    bit          hold_arm  = 1'b0;
    bit          hold_done = 1'b0;
    int          rx_wait   = 0;

    archive_entry_table_parser_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                trk.set_file_length(i_cfg_data);
            if (i_valid && !o_stall)
                trk.take_word(i_data);
            if (o_valid && !i_stall)
                trk.check_word(o_data);
        end
    end

    // Receiver: short random stall bursts, plus one long hold to back up the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
            i_stall <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_stall <= 1'b1;
        end else if (hold_arm && !hold_done && o_valid) begin
            hold_done = 1'b1;
            rx_wait   = LONG_HOLD - 1;
            i_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_wait = $urandom_range(0, 4);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic void put_byte(input logic [7:0] b);
        t_in w;
        w.op        = 1'b0;
        w.data_byte = b;
        stim_words = {stim_words, w};
    endfunction

    function automatic void put_restart();
        t_in w;
        w.op        = 1'b1;
        w.data_byte = 8'($urandom());
        stim_words = {stim_words, w};
    endfunction

    function automatic void put_be32(input logic [31:0] v);
        for (int i = 3; i >= 0; i--)
            put_byte(v[8*i +: 8]);
    endfunction

    function automatic void build_long_name(input int nlen);
        logic [31:0] hend;
        hend = 32'(12 + nlen + 9);
        put_restart();
        put_be32(SIG_STORED);
        put_be32(hend - 32'(HDR_BIAS));
        put_be32(32'($urandom()));
        repeat (nlen) put_byte(8'($urandom_range(1, 255)));
        put_byte(8'h00);
        put_be32(hend);
        put_be32(32'd16);
    endfunction

    function automatic void build_archive(input t_arc_kind kind);
        logic [31:0] sig;
        logic [31:0] off;
        logic [31:0] sz;
        logic [31:0] hsize;
        logic [31:0] unp;
        logic [32:0] hend;
        int          n_ent;
        int          bad_at;
        int          bad_how;
        int          start;
        int          cut;
        int          nl[6];
        bit          comp_form;
        start = stim_words.size();
        put_restart();
        if (kind == A_NOISE) begin
            repeat ($urandom_range(1, 16)) put_byte(8'($urandom()));
            return;
        end
        comp_form = $urandom_range(0, 1);
        n_ent     = $urandom_range((kind == A_BADENTRY) ? 1 : 0, 6);
        hend      = 33'd12;
        for (int i = 0; i < n_ent; i++) begin
            nl[i] = $urandom_range(1, 6);
            hend += 33'(nl[i] + (comp_form ? 13 : 9));
        end
        bad_at  = (kind == A_BADENTRY) ? $urandom_range(0, n_ent - 1) : -1;
        bad_how = $urandom_range(0, 3);
        case (kind)
            A_BADSIG: sig = $urandom_range(0, 1) ? 32'($urandom())
                                                 : SIG_COMP ^ (32'd1 << $urandom_range(0, 31));
            A_UPPER:  sig = SIG_UPPER;
            default:  sig = comp_form ? SIG_COMP : SIG_STORED;
        endcase
        hsize = 32'(hend - HDR_BIAS);
        if (kind == A_SIZE_SKEW) begin
            case ($urandom_range(0, 2))
                0:       hsize += $urandom_range(1, 12);
                1:       hsize -= $urandom_range(1, 12);
                default: hsize = $urandom();
            endcase
        end
        put_be32(sig);
        put_be32(hsize);
        put_be32(32'($urandom()));
        for (int i = 0; i < n_ent; i++) begin
            if (!(i == bad_at && bad_how == 0))
                repeat (nl[i]) put_byte(8'($urandom_range(1, 255)));
            put_byte(8'h00);
            if (i == bad_at && bad_how == 1) begin
                // nonzero size placed inside the header
                off = $urandom_range(0, 32'(hend) - 1);
                sz  = $urandom_range(1, 64);
            end else if (i == bad_at && bad_how == 2) begin
                off = (cur_len == 32'hFFFF_FFFF) ? cur_len
                                                 : $urandom_range(cur_len + 1, 32'hFFFF_FFFF);
                sz  = $urandom_range(1, 64);
            end else if (i == bad_at && bad_how == 3) begin
                // run just past the end; wraps 32 bits at the top length
                sz  = $urandom_range(0, 255);
                off = cur_len - sz;
                sz  = sz + 1 + $urandom_range(0, 1000);
            end else if ({1'b0, cur_len} >= hend) begin
                off = $urandom_range(32'(hend), cur_len);
                sz  = $urandom_range(0, cur_len - off);
                if ($urandom_range(0, 7) == 0) begin
                    off = $urandom_range(0, cur_len);
                    sz  = '0;
                end
            end else begin
                off = cur_len;
                sz  = '0;
            end
            put_be32(off);
            put_be32(sz);
            if (comp_form) begin
                case ($urandom_range(0, 2))
                    0:       unp = '0;
                    1:       unp = sz;
                    default: unp = $urandom();
                endcase
                put_be32(unp);
            end
        end
        if (kind == A_CUT) begin
            cut = $urandom_range(start + 2, stim_words.size() - 1);
            while (stim_words.size() > cut)
                void'(stim_words.pop_back());
        end else if ($urandom_range(0, 4) == 0) begin
            // trailing bytes after the table end; once the parse has halted the block ignores them
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom()));
        end
    endfunction

    function automatic t_arc_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return A_GOOD;
        if (r < 62) return A_BADSIG;
        if (r < 67) return A_UPPER;
        if (r < 77) return A_SIZE_SKEW;
        if (r < 87) return A_BADENTRY;
        if (r < 95) return A_CUT;
        return A_NOISE;
    endfunction

    task automatic send_word(input t_in w);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_data  <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_queue();
        while (stim_words.size() > 0)
            send_word(stim_words.pop_front());
    endtask

    // Drain all owed words, let the pipe go quiet, then load the file length.
    task automatic settle_and_write(input logic [31:0] fl);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (trk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        cur_len = fl;
        i_cfg_we   <= 1'b1;
        i_cfg_data <= fl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] fl, input int unsigned quota,
                             input bit extras, input bit quiet);
        int unsigned goal;
        settle_and_write(fl);
        goal = trk.live_bytes + quota;
        if (extras) begin
            build_long_name(MAX_NAME_BYTES);
            send_queue();
            hold_arm = 1'b1;
        end
        while (trk.live_bytes < goal) begin
            idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
            build_archive(pick_kind());
            send_queue();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero file length: first byte reads past the end
        put_restart();
        put_byte(8'hA5);
        send_queue();
        settle_and_write(32'hFFFF_FFFF);
        put_restart();
        put_be32(SIG_UPPER);
        put_restart();
        put_be32(32'h00FF_1234);
        // empty table, then a byte after done
        put_restart();
        put_be32(SIG_STORED);
        put_be32(32'd4);
        put_be32(32'hFFFF_FFFF);
        put_byte(8'hFF);
        send_queue();

        run_phase(32'hFFFF_FFFF, 130, 1'b0, 1'b0);
        run_phase(32'd4096, 1300, 1'b1, 1'b0);
        run_phase($urandom_range(8, 120), 90, 1'b0, 1'b0);
        run_phase(32'd0, 30, 1'b0, 1'b0);
        run_phase(32'($urandom()), 90, 1'b0, 1'b0);
        run_phase(32'd1500, 90, 1'b0, 1'b0);
        run_phase(32'hFFFF_FFFF, 100, 1'b0, 1'b1);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (trk.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);
        if (trk.errors == 0 && trk.pending() == 0)
            $display("PASS archive_entry_table_parser_core");
        else
            $display("FAIL archive_entry_table_parser_core");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL archive_entry_table_parser_core");
        $finish;
    end

endmodule

### archive_entry_table_parser_core.f
sv/aetp_pkg.sv
sv/aetp_parse.sv
sv/aetp_outq.sv
sv/archive_entry_table_parser_core.sv
test/tb.sv
